@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the compensation core RTL.
// Each macro builds one labeled concurrent assertion on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, including during reset.
`define BPTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/bptc_pkg.sv @@
// Package for the barometric compensation core: register indexes, constants,
// and the arithmetic helpers shared by the pipeline and its divider.
// No dependencies.
package bptc_pkg;

  // Configuration register indexes (word address bits [4:2]).
  typedef enum logic [2:0] {
    REG_AC1     = 3'd0,
    REG_AC2     = 3'd1,
    REG_AC3     = 3'd2,
    REG_AC4     = 3'd3,
    REG_AC5_AC6 = 3'd4,
    REG_B1_B2   = 3'd5,
    REG_MC_MD   = 3'd6,
    REG_OSS     = 3'd7
  } reg_idx_e;

  localparam int unsigned ADDR_W = 5;

  // Compensation constants.
  localparam logic [31:0] C_B5_ROUND  = 32'd8;
  localparam logic [31:0] C_B6_OFFSET = 32'd4000;
  localparam logic [31:0] C_B4_BIAS   = 32'd32768;
  localparam logic [31:0] C_B7_SCALE  = 32'd50000;
  localparam logic [31:0] C_P_COEF1   = 32'd3038;
  localparam logic [31:0] C_P_COEF2   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] C_P_BIAS    = 32'd3791;

  // One partial result of the restoring divider.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nq;  // dividend bits shift out, quotient bits shift in
  } div_state_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

  // One restoring division step: one quotient bit.
  function automatic div_state_t div_step(input div_state_t s, input logic [31:0] den);
    logic [32:0] trial;
    logic        ge;
    div_state_t  r;
    trial = {s.rem, s.nq[31]};
    ge    = (trial >= {1'b0, den});
    r.rem = ge ? 32'(trial - {1'b0, den}) : trial[31:0];
    r.nq  = {s.nq[30:0], ge};
    return r;
  endfunction

endpackage

@@ hw/rtl/bptc_div_pipe.sv @@
// Fully pipelined 32-bit unsigned divider, one quotient bit per stage.
// Depends on bptc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bptc_div_pipe import bptc_pkg::*; #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       num_i,
  input  logic [31:0]       den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       quot_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned STAGES = 32;

  logic              v_q    [STAGES];
  div_state_t        st_q   [STAGES];
  logic [31:0]       den_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];
  div_state_t        st_d   [STAGES];

  // Each stage resolves one quotient bit from the stage before it.
  always_comb begin
    st_d[0] = div_step('{rem: 32'd0, nq: num_i}, den_i);
    for (int i = 1; i < STAGES; i++) begin
      st_d[i] = div_step(st_q[i-1], den_q[i-1]);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < STAGES; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= st_d[0];
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int i = 1; i < STAGES; i++) begin
        st_q[i]   <= st_d[i];
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign quot_o  = st_q[STAGES-1].nq;
  assign side_o  = side_q[STAGES-1];

  `BPTC_ASSERT(a_div_hold, !en_i && valid_o |=> $stable(quot_o) && $stable(valid_o), "divider moved while held")

endmodule

@@ hw/rtl/baro_temp_pressure_compensation_core.sv @@
// Barometric temperature and pressure compensation core. Each input word
// (raw temperature, raw pressure) yields one result word; a new word is
// taken every cycle unless the pipeline is held, and the whole pipeline
// advances together, held only while a finished result waits at the
// output. Two 32-stage pipelined dividers (temperature and pressure)
// set most of the latency. Calibration is written through the APB port.
`include "assert_macros.svh"
module baro_temp_pressure_compensation_core import bptc_pkg::*; #(
  parameter int PRESSURE_OFFSET = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       raw_temperature_i,
  input  logic [23:0]       raw_pressure_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [27:0]       temperature_tenths_o,
  output logic [31:0]       pressure_pa_o,
  output logic              divide_fault_o
);

  // Configuration registers.
  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q;
  logic [31:0] ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q <= '0; ac2_q <= '0; ac3_q <= '0; ac4_q <= '0;
      ac56_q <= '0; b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_AC1:     ac1_q  <= pwdata[15:0];
        REG_AC2:     ac2_q  <= pwdata[15:0];
        REG_AC3:     ac3_q  <= pwdata[15:0];
        REG_AC4:     ac4_q  <= pwdata[15:0];
        REG_AC5_AC6: ac56_q <= pwdata;
        REG_B1_B2:   b12_q  <= pwdata;
        REG_MC_MD:   mcmd_q <= pwdata;
        REG_OSS:     oss_q  <= pwdata[1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AC1:     prdata = {16'd0, ac1_q};
      REG_AC2:     prdata = {16'd0, ac2_q};
      REG_AC3:     prdata = {16'd0, ac3_q};
      REG_AC4:     prdata = {16'd0, ac4_q};
      REG_AC5_AC6: prdata = ac56_q;
      REG_B1_B2:   prdata = b12_q;
      REG_MC_MD:   prdata = mcmd_q;
      REG_OSS:     prdata = {30'd0, oss_q};
      default:     prdata = '0;
    endcase
  end

  // Whole pipeline moves unless a result waits at a stalled output.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: (UT - AC6) * AC5.
  logic        v1_q;
  logic [31:0] t1_q;
  logic [23:0] up1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q  <= 32'(({16'd0, raw_temperature_i} - {16'd0, ac56_q[15:0]}) *
                   {16'd0, ac56_q[31:16]});
      up1_q <= raw_pressure_i;
    end
  end

  // Stage 2: temperature divisor and sign handling for the signed divide.
  logic        v2_q;
  logic [31:0] num2_q, den2_q;
  logic [57:0] side2_q;
  logic [31:0] x1t, den_s, num_s;
  logic        neg_s;
  always_comb begin
    x1t   = asr32(t1_q, 5'd15);
    den_s = x1t + sx16(mcmd_q[15:0]);
    num_s = {{5{mcmd_q[31]}}, mcmd_q[31:16], 11'd0};
    neg_s = num_s[31] ^ den_s[31];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num2_q  <= num_s[31] ? 32'(-num_s) : num_s;
      den2_q  <= den_s[31] ? 32'(-den_s) : den_s;
      side2_q <= {x1t, up1_q, (den_s == 32'd0), neg_s};
    end
  end

  logic        vt;
  logic [31:0] qt;
  logic [57:0] sidet;
  bptc_div_pipe #(.SIDE_W(58)) u_div_temp (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v2_q), .num_i(num2_q), .den_i(den2_q), .side_i(side2_q),
    .valid_o(vt), .quot_o(qt), .side_o(sidet)
  );

  // Stage 3: B5, temperature and B6.
  logic        v3_q, f3_q;
  logic [27:0] temp3_q;
  logic [31:0] b6_3_q;
  logic [23:0] up3_q;
  logic [31:0] b5;
  always_comb begin
    b5 = sidet[57:26] + (sidet[0] ? 32'(-qt) : qt);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= vt;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp3_q <= 28'(asr32(b5 + C_B5_ROUND, 5'd4));
      b6_3_q  <= b5 - C_B6_OFFSET;
      up3_q   <= sidet[25:2];
      f3_q    <= sidet[1];
    end
  end

  // Stage 4: B6 squared, AC2 * B6, AC3 * B6.
  logic        v4_q, f4_q;
  logic [27:0] temp4_q;
  logic [23:0] up4_q;
  logic [31:0] sq4_q, a2_4_q, a3_4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq4_q   <= 32'(b6_3_q * b6_3_q);
      a2_4_q  <= 32'(sx16(ac2_q) * b6_3_q);
      a3_4_q  <= 32'(sx16(ac3_q) * b6_3_q);
      temp4_q <= temp3_q;
      up4_q   <= up3_q;
      f4_q    <= f3_q;
    end
  end

  // Stage 5: B2 and B1 terms.
  logic        v5_q, f5_q;
  logic [27:0] temp5_q;
  logic [23:0] up5_q;
  logic [31:0] a2_5_q, a3_5_q, mb2_5_q, mb1_5_q, bb;
  assign bb = asr32(sq4_q, 5'd12);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mb2_5_q <= 32'(sx16(b12_q[15:0]) * bb);
      mb1_5_q <= 32'(sx16(b12_q[31:16]) * bb);
      a2_5_q  <= a2_4_q;
      a3_5_q  <= a3_4_q;
      temp5_q <= temp4_q;
      up5_q   <= up4_q;
      f5_q    <= f4_q;
    end
  end

  // Stage 6: B3 and the B4 multiplicand.
  logic        v6_q, f6_q;
  logic [27:0] temp6_q;
  logic [23:0] up6_q;
  logic [31:0] b3_6_q, s6_q, x3a, x3b;
  always_comb begin
    x3a = asr32(mb2_5_q, 5'd11) + asr32(a2_5_q, 5'd11);
    x3b = asr32(asr32(a3_5_q, 5'd13) + asr32(mb1_5_q, 5'd16) + 32'd2, 5'd2);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b3_6_q  <= asr32(32'(((sx16(ac1_q) << 2) + x3a) << oss_q) + 32'd2, 5'd2);
      s6_q    <= x3b + C_B4_BIAS;
      temp6_q <= temp5_q;
      up6_q   <= up5_q;
      f6_q    <= f5_q;
    end
  end

  // Stage 7: B4 and UP - B3.
  logic        v7_q, f7_q;
  logic [27:0] temp7_q;
  logic [31:0] b4_7_q, diff7_q;
  logic [3:0]  up_sh;
  logic [31:0] prod_b4;
  always_comb begin
    up_sh   = 4'd8 - {2'd0, oss_q};
    prod_b4 = 32'({16'd0, ac4_q} * s6_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b4_7_q  <= prod_b4 >> 15;
      diff7_q <= {8'd0, up6_q >> up_sh} - b3_6_q;
      temp7_q <= temp6_q;
      f7_q    <= f6_q;
    end
  end

  // Stage 8: B7 and the pressure dividend.
  logic        v8_q;
  logic [31:0] num8_q, den8_q;
  logic [29:0] side8_q;
  logic [31:0] b7;
  assign b7 = 32'(diff7_q * (C_B7_SCALE >> oss_q));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (adv) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num8_q  <= b7[31] ? b7 : {b7[30:0], 1'b0};
      den8_q  <= b4_7_q;
      side8_q <= {temp7_q, f7_q || (b4_7_q == 32'd0), b7[31]};
    end
  end

  logic        vp;
  logic [31:0] qp;
  logic [29:0] sidep;
  bptc_div_pipe #(.SIDE_W(30)) u_div_pres (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v8_q), .num_i(num8_q), .den_i(den8_q), .side_i(side8_q),
    .valid_o(vp), .quot_o(qp), .side_o(sidep)
  );

  // Stage 9: raw pressure P.
  logic        v9_q, f9_q;
  logic [27:0] temp9_q;
  logic [31:0] p9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (adv) v9_q <= vp;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p9_q    <= sidep[0] ? {qp[30:0], 1'b0} : qp;
      temp9_q <= sidep[29:2];
      f9_q    <= sidep[1];
    end
  end

  // Stage 10: (P >> 8) squared and the linear correction term.
  logic        v10_q, f10_q;
  logic [27:0] temp10_q;
  logic [31:0] p10_q, sq10_q, m10_q, s8;
  assign s8 = asr32(p9_q, 5'd8);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else if (adv) v10_q <= v9_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq10_q   <= 32'(s8 * s8);
      m10_q    <= 32'(C_P_COEF2 * p9_q);
      p10_q    <= p9_q;
      temp10_q <= temp9_q;
      f10_q    <= f9_q;
    end
  end

  // Stage 11: quadratic correction term.
  logic        v11_q, f11_q;
  logic [27:0] temp11_q;
  logic [31:0] p11_q, m11_q, q11_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else if (adv) v11_q <= v10_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      q11_q    <= 32'(sq10_q * C_P_COEF1);
      m11_q    <= m10_q;
      p11_q    <= p10_q;
      temp11_q <= temp10_q;
      f11_q    <= f10_q;
    end
  end

  // Output word register: final pressure and fault zeroing.
  logic [27:0] temp_o_q;
  logic [31:0] pres_o_q, pres;
  logic        fault_o_q;
  always_comb begin
    pres = p11_q + asr32(asr32(q11_q, 5'd16) + asr32(m11_q, 5'd16) + C_P_BIAS, 5'd4)
         + 32'(PRESSURE_OFFSET);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= v11_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp_o_q  <= f11_q ? 28'd0 : temp11_q;
      pres_o_q  <= f11_q ? 32'd0 : pres;
      fault_o_q <= f11_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign temperature_tenths_o = temp_o_q;
  assign pressure_pa_o        = pres_o_q;
  assign divide_fault_o       = fault_o_q;

  `BPTC_ASSERT(a_fault_zero, out_valid_o && divide_fault_o |-> temperature_tenths_o == 28'd0 && pressure_pa_o == 32'd0, "fault word carries nonzero results")
  `BPTC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid during reset")
  `BPTC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(pressure_pa_o) && $stable(temperature_tenths_o), "stalled word changed")

endmodule

@@ sim/baro_temp_pressure_compensation_core_tb.sv @@
// Testbench for baro_temp_pressure_compensation_core: random and directed raw
// sample words, with results checked against an in-bench compensation predictor.
// Depends on bptc_pkg and the core RTL only.
module baro_temp_pressure_compensation_core_tb import bptc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 76;
  localparam int WDOG_MAX  = 4000;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] up;
  } sample_t;

  typedef struct packed {
    logic [27:0] temp;
    logic [31:0] pres;
    logic        fault;
  } comp_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, divide_fault_o;
  logic [15:0] raw_temperature_i;
  logic [23:0] raw_pressure_i;
  logic [27:0] temperature_tenths_o;
  logic [31:0] pressure_pa_o;

  baro_temp_pressure_compensation_core u_dut (.*);

  // Calibration shadow used by the predictor.
  logic [31:0] cal [8];

  sample_t pending_words[$];
  comp_t   expected_results[$];
  int      mismatches;
  bit      long_hold;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [31:0] div_signed(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Compensation of one raw sample pair under the current calibration.
  function automatic comp_t compensate(sample_t s);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b5, b6, bb, b3, b4, b7, p, up, den, t;
    int oss;
    comp_t r;
    oss = cal[REG_OSS] & 3;
    ac1 = sext16(cal[REG_AC1][15:0]);
    ac2 = sext16(cal[REG_AC2][15:0]);
    ac3 = sext16(cal[REG_AC3][15:0]);
    ac4 = {16'h0, cal[REG_AC4][15:0]};
    ac5 = {16'h0, cal[REG_AC5_AC6][31:16]};
    ac6 = {16'h0, cal[REG_AC5_AC6][15:0]};
    b1 = sext16(cal[REG_B1_B2][31:16]);
    b2 = sext16(cal[REG_B1_B2][15:0]);
    mc = sext16(cal[REG_MC_MD][31:16]);
    md = sext16(cal[REG_MC_MD][15:0]);
    r = '{temp: '0, pres: '0, fault: 1'b1};
    x1 = sra(({16'h0, s.ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = div_signed(mc << 11, den);
    b5 = x1 + x2;
    t = sra(b5 + 32'd8, 4);
    up = {8'h0, s.up} >> (8 - oss);
    b6 = b5 - 32'd4000;
    bb = sra(b6 * b6, 12);
    x1 = sra(b2 * bb, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * bb, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> oss);
    p = (b7 < 32'h8000_0000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(32'hFFFF_E343 * p, 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    r.temp = t[27:0];
    r.pres = p;
    r.fault = 1'b0;
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cal[idx] = value;
  endtask

  // Typical calibration; a few words are perturbed per phase.
  task automatic load_cal(int flavor);
    write_reg(REG_AC1, flavor == 2 ? 32'h8000 : 32'd408);
    write_reg(REG_AC2, flavor == 2 ? 32'h7FFF : -32'sd72);
    write_reg(REG_AC3, flavor == 1 ? $urandom : -32'sd14383);
    write_reg(REG_AC4, flavor == 2 ? 32'hFFFF : 32'd32741);
    write_reg(REG_AC5_AC6, flavor == 1 ? $urandom : {16'd32757, 16'd23153});
    write_reg(REG_B1_B2, flavor == 2 ? 32'h8000_7FFF : {16'd6190, 16'd4});
    write_reg(REG_MC_MD, flavor == 1 ? $urandom : {-16'sd8711, 16'd2868});
    write_reg(REG_OSS, flavor == 2 ? 32'hFFFF_FFFF : 32'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic sample_t rand_word();
    sample_t s;
    s.ut = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(20000, 32000));
    s.up = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(8000000, 11000000));
    return s;
  endfunction

  // Stimulus and phase sequencing.
  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    for (int i = 0; i < 8; i++) cal[i] = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // All-zero calibration: every word divides by zero.
    pending_words.push_back('{ut: 16'h0, up: 24'h0});
    pending_words.push_back('{ut: 16'hFFFF, up: 24'hFFFFFF});
    drain();
    load_cal(0);
    pending_words.push_back('{ut: 16'd27898, up: 24'd23843 << 8});
    pending_words.push_back('{ut: 16'h0, up: 24'h0});
    pending_words.push_back('{ut: 16'hFFFF, up: 24'hFFFFFF});
    pending_words.push_back('{ut: 16'h8000, up: 24'h800000});
    pending_words.push_back('{ut: 16'h5555, up: 24'hAAAAAA});
    pending_words.push_back('{ut: 16'hAAAA, up: 24'h555555});
    drain();
    // Temperature divisor zero: x1 = 0 with ut = ac6, md = 0.
    write_reg(REG_MC_MD, {16'd100, 16'd0});
    pending_words.push_back('{ut: 16'd23153, up: 24'd1000});
    drain();
    // Pressure divisor zero: ac4 = 0.
    write_reg(REG_MC_MD, {-16'sd8711, 16'd2868});
    write_reg(REG_AC4, 32'd0);
    pending_words.push_back('{ut: 16'd27898, up: 24'd6000000});
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      load_cal(ph % 3);
      // Long receiver hold while the sender keeps offering more words
      // than the pipeline can hold.
      if (ph == 3) long_hold = 1'b1;
      for (int i = 0; i < ((ph == 3) ? 150 : 60); i++) pending_words.push_back(rand_word());
      drain();
      long_hold = 1'b0;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver: bursts with random gaps. The head of the queue is the word on
  // the bus until it is accepted.
  int burst_left, gap_left;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      raw_temperature_i <= '0;
      raw_pressure_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(compensate('{ut: raw_temperature_i,
                                                up: raw_pressure_i}));
        void'(pending_words.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_next();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic s_next();
    sample_t s;
    s = pending_words[0];
    in_valid_i <= 1'b1;
    raw_temperature_i <= s.ut;
    raw_pressure_i <= s.up;
    if (burst_left == 0) begin
      burst_left <= $urandom_range(1, 30);
      gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
    end else begin
      burst_left <= burst_left - 1;
    end
  endtask

  // Receiver stall pattern, with one long hold-off counted here on request.
  int stall_mode;
  int hold_left;
  bit hold_done;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (long_hold && !hold_done) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      out_stall_i <= (hold_left > 0) ||
                     (stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                     (stall_mode == 2 && $urandom_range(0, 1) == 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always_ff @(posedge clk_i) begin
    comp_t exp_r;
    if (!rst_ni) begin
      mismatches <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word");
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.temp !== temperature_tenths_o || exp_r.pres !== pressure_pa_o ||
            exp_r.fault !== divide_fault_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                     $signed(exp_r.temp), $signed(exp_r.pres), exp_r.fault,
                     $signed(temperature_tenths_o), $signed(pressure_pa_o),
                     divide_fault_o);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always_ff @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (expected_results.size() == 0 && pending_words.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WDOG_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial long_hold = 1'b0;
endmodule
